FILE: hdl/snpt_pkg.sv
`timescale 1ns / 1ps

package snpt_pkg;

	localparam int SLOT_W = 8;

	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] REG_ONLINE_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_TICK_STEP      = 2'd1;
	localparam logic [1:0] REG_BATT_FULL      = 2'd2;
	localparam logic [1:0] REG_BATT_EMPTY     = 2'd3;

	localparam logic [31:0] RST_ONLINE_TIMEOUT = 32'd1800000;
	localparam logic [15:0] RST_TICK_STEP      = 16'd1000;
	localparam logic [15:0] RST_BATT_FULL      = 16'd3000;
	localparam logic [15:0] RST_BATT_EMPTY     = 16'd2200;

	localparam logic [6:0] PCT_FULL = 7'd100;
	localparam logic [2:0] DIV_STEPS_M1 = 3'd6;

	typedef enum logic [2:0] {
		RS_UPDATED = 3'd0,
		RS_NEW     = 3'd1,
		RS_FULL    = 3'd2,
		RS_IGNORED = 3'd3,
		RS_TICK    = 3'd4,
		RS_READ    = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [7:0]         frame_length;
		logic [7:0]         node_addr;
		logic [7:0]         switch1_byte;
		logic [7:0]         switch2_byte;
		logic [7:0]         switch3_byte;
		logic [31:0]        chip_ident;
		logic [15:0]        frame_seq;
		logic [15:0]        supply_mv;
		logic signed [7:0]  rssi_dbm;
		logic [4:0]         read_slot;
	} in_t;

	typedef struct packed {
		status_t            status;
		logic [4:0]         slot_out;
		logic               entry_valid;
		logic [7:0]         node_out;
		logic [31:0]        chip_ident_out;
		logic [2:0]         switch_flags;
		logic [15:0]        frame_seq_out;
		logic [15:0]        supply_mv_out;
		logic [6:0]         battery_pct;
		logic signed [7:0]  rssi_out;
		logic               node_online;
		logic [5:0]         used_count;
	} out_t;

	typedef struct packed {
		logic [7:0]         node;
		logic [31:0]        chip_ident;
		logic [2:0]         switches;
		logic [15:0]        seq;
		logic [15:0]        supply;
		logic signed [7:0]  rssi;
		logic [31:0]        last_seen;
	} entry_t;

	typedef struct packed {
		logic               active;
		logic               read_mode;
		logic [7:0]         key;
		logic [SLOT_W-1:0]  rd_idx;
		logic               hit;
		logic [SLOT_W-1:0]  hit_idx;
		logic               free_ok;
		logic [SLOT_W-1:0]  free_idx;
		logic               cap_used;
		entry_t             cap;
	} probe_t;

	typedef struct packed {
		logic               en;
		logic [SLOT_W-1:0]  idx;
		entry_t             entry;
	} wr_t;

endpackage

FILE: hdl/sensor_node_presence_table.sv
`timescale 1ns / 1ps

// Tick and ignored items: result goes from the done state to the output register.
// Frame and read items: probe walks the slot chain, one cell per cycle;
// then the battery divide state when needed, the done state and the output register.
// One item in flight; the next item is taken once the result is in the output register.
// Reset clears slot used flags, clock, used count and loads register defaults.
module sensor_node_presence_table #(
	parameter int TABLE_SLOTS = 32,
	parameter int FRAME_LEN   = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  snpt_pkg::in_t     req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output snpt_pkg::out_t    rsp,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [31:0]                   timeout_q;
	logic [15:0]                   tick_step_q;
	logic [15:0]                   full_q;
	logic [15:0]                   empty_q;
	logic [31:0]                   clock_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          launch_act_q;
	snpt_pkg::probe_t              launch_q;
	snpt_pkg::in_t                 item_q;
	snpt_pkg::out_t                res_q;
	snpt_pkg::out_t                rsp_q;
	logic                          rsp_valid_q;
	logic [22:0]                   rem_q;
	logic [21:0]                   dsh_q;
	logic [6:0]                    quo_q;
	logic [2:0]                    step_q;

	snpt_pkg::probe_t              head;
	snpt_pkg::probe_t              chain [TABLE_SLOTS+1];
	snpt_pkg::probe_t              chain_out;
	snpt_pkg::wr_t                 wr;

	logic                          accept;
	logic                          scan_req;
	logic                          scan_done;
	logic [snpt_pkg::SLOT_W-1:0]   slot_sel;
	logic                          entry_there;
	logic [15:0]                   bat_mv;
	logic                          bat_hi;
	logic                          bat_lo;
	logic                          bat_div;
	logic [15:0]                   bat_diff;
	logic [15:0]                   bat_span;
	logic [22:0]                   bat_prod;
	logic [31:0]                   age;
	logic                          div_ge;
	logic [6:0]                    quo_nxt;
	logic                          load;
	snpt_pkg::out_t                res_init;
	snpt_pkg::probe_t              launch_nxt;
	snpt_pkg::out_t                rsp_nxt;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign scan_req  = ((req.operation == snpt_pkg::OP_FRAME) &&
		(req.frame_length == FRAME_LEN[7:0])) || (req.operation == snpt_pkg::OP_READ);

	always_comb begin
		head        = launch_q;
		head.active = launch_act_q;
	end

	assign chain[0]  = head;
	assign chain_out = chain[TABLE_SLOTS];

	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		snpt_cell #(
			.CELL_IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.probe_in  (chain[i]),
			.wr        (wr),
			.probe_out (chain[i+1])
		);
	end

	assign scan_done = (state_q == ST_SCAN) && chain_out.active;
	assign slot_sel  = chain_out.hit ? chain_out.hit_idx : chain_out.free_idx;

	always_comb begin
		wr.en               = scan_done && !chain_out.read_mode &&
			(chain_out.hit || chain_out.free_ok);
		wr.idx              = slot_sel;
		wr.entry.node       = item_q.node_addr;
		wr.entry.chip_ident = item_q.chip_ident;
		wr.entry.switches   = {|item_q.switch3_byte, |item_q.switch2_byte,
			|item_q.switch1_byte};
		wr.entry.seq        = item_q.frame_seq;
		wr.entry.supply     = item_q.supply_mv;
		wr.entry.rssi       = item_q.rssi_dbm;
		wr.entry.last_seen  = clock_q;
	end

	always_comb begin
		res_init             = '0;
		res_init.status      = (req.operation == snpt_pkg::OP_TICK) ?
			snpt_pkg::RS_TICK : snpt_pkg::RS_IGNORED;
		launch_nxt           = '0;
		launch_nxt.read_mode = (req.operation == snpt_pkg::OP_READ);
		launch_nxt.key       = req.node_addr;
		launch_nxt.rd_idx    = {{(snpt_pkg::SLOT_W-5){1'b0}}, req.read_slot};
		rsp_nxt              = res_q;
		rsp_nxt.used_count   = 6'(cnt_q);
	end

	assign entry_there = chain_out.read_mode ? chain_out.cap_used : wr.en;
	assign bat_mv      = chain_out.read_mode ? chain_out.cap.supply : item_q.supply_mv;
	assign bat_hi      = (bat_mv >= full_q);
	assign bat_lo      = (bat_mv <= empty_q);
	assign bat_div     = entry_there && !bat_hi && !bat_lo;
	assign bat_diff    = bat_mv - empty_q;
	assign bat_span    = full_q - empty_q;
	assign bat_prod    = {7'd0, bat_diff} * {16'd0, snpt_pkg::PCT_FULL};
	assign age         = clock_q - chain_out.cap.last_seen;

	assign div_ge  = (rem_q >= {1'b0, dsh_q});
	assign quo_nxt = {quo_q[5:0], div_ge};

	assign load = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			timeout_q    <= snpt_pkg::RST_ONLINE_TIMEOUT;
			tick_step_q  <= snpt_pkg::RST_TICK_STEP;
			full_q       <= snpt_pkg::RST_BATT_FULL;
			empty_q      <= snpt_pkg::RST_BATT_EMPTY;
			clock_q      <= '0;
			cnt_q        <= '0;
			launch_act_q <= 1'b0;
			step_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			launch_act_q <= accept && scan_req && (req.operation != snpt_pkg::OP_TICK);
			if (cfg_we) begin
				case (cfg_index)
					snpt_pkg::REG_ONLINE_TIMEOUT: timeout_q   <= cfg_data;
					snpt_pkg::REG_TICK_STEP:      tick_step_q <= cfg_data[15:0];
					snpt_pkg::REG_BATT_FULL:      full_q      <= cfg_data[15:0];
					snpt_pkg::REG_BATT_EMPTY:     empty_q     <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.operation == snpt_pkg::OP_TICK) begin
							clock_q <= clock_q + {16'd0, tick_step_q};
							state_q <= ST_DONE;
						end else if (scan_req) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (chain_out.active) begin
						if (wr.en && !chain_out.hit) begin
							cnt_q <= cnt_q + 1'b1;
						end
						step_q  <= snpt_pkg::DIV_STEPS_M1;
						state_q <= bat_div ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= req;
			res_q    <= res_init;
			launch_q <= launch_nxt;
		end
		if (scan_done) begin
			if (chain_out.read_mode) begin
				res_q.status   <= snpt_pkg::RS_READ;
				res_q.slot_out <= item_q.read_slot;
				if (chain_out.cap_used) begin
					res_q.entry_valid    <= 1'b1;
					res_q.node_out       <= chain_out.cap.node;
					res_q.chip_ident_out <= chain_out.cap.chip_ident;
					res_q.switch_flags   <= chain_out.cap.switches;
					res_q.frame_seq_out  <= chain_out.cap.seq;
					res_q.supply_mv_out  <= chain_out.cap.supply;
					res_q.rssi_out       <= chain_out.cap.rssi;
					res_q.node_online    <= (age < timeout_q);
				end
			end else if (wr.en) begin
				res_q.status         <= chain_out.hit ? snpt_pkg::RS_UPDATED : snpt_pkg::RS_NEW;
				res_q.slot_out       <= slot_sel[4:0];
				res_q.entry_valid    <= 1'b1;
				res_q.node_out       <= wr.entry.node;
				res_q.chip_ident_out <= wr.entry.chip_ident;
				res_q.switch_flags   <= wr.entry.switches;
				res_q.frame_seq_out  <= wr.entry.seq;
				res_q.supply_mv_out  <= wr.entry.supply;
				res_q.rssi_out       <= wr.entry.rssi;
				res_q.node_online    <= (timeout_q != '0);
			end else begin
				res_q.status <= snpt_pkg::RS_FULL;
			end
			if (entry_there) begin
				res_q.battery_pct <= bat_hi ? snpt_pkg::PCT_FULL : '0;
			end
			rem_q <= bat_prod;
			dsh_q <= {bat_span, 6'd0};
			quo_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (div_ge) begin
				rem_q <= rem_q - {1'b0, dsh_q};
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= quo_nxt;
			if (step_q == '0) begin
				res_q.battery_pct <= quo_nxt;
			end
		end
		if (load) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_SLOTS))
		else $error("used count above table size");

	a_probe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain_out.active |-> (state_q == ST_SCAN))
		else $error("probe left the chain outside scan");

	a_cnt_by_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> $past(wr.en && !chain_out.hit))
		else $error("used count moved without a slot allocation");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> ((state_q == ST_DIV) || (state_q == ST_DONE)))
		else $error("divide left to a wrong state");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.battery_pct <= snpt_pkg::PCT_FULL))
		else $error("battery percent above 100");

endmodule

FILE: hdl/snpt_cell.sv
`timescale 1ns / 1ps

module snpt_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  snpt_pkg::probe_t  probe_in,
	input  snpt_pkg::wr_t     wr,
	output snpt_pkg::probe_t  probe_out
);

	localparam logic [snpt_pkg::SLOT_W-1:0] ME = CELL_IDX[snpt_pkg::SLOT_W-1:0];

	logic              used_q;
	snpt_pkg::entry_t  entry_q;
	snpt_pkg::probe_t  nxt;
	snpt_pkg::probe_t  probe_q;
	logic              active_q;
	logic              me_wr;

	assign me_wr = wr.en && (wr.idx == ME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (me_wr) begin
			used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (me_wr) begin
			entry_q <= wr.entry;
		end
	end

	always_comb begin
		nxt = probe_in;
		if (probe_in.read_mode) begin
			if (probe_in.rd_idx == ME) begin
				nxt.cap_used = used_q;
				nxt.cap      = entry_q;
			end
		end else begin
			if (!probe_in.hit && used_q && (entry_q.node == probe_in.key)) begin
				nxt.hit     = 1'b1;
				nxt.hit_idx = ME;
			end
			if (!probe_in.free_ok && !used_q) begin
				nxt.free_ok  = 1'b1;
				nxt.free_idx = ME;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else begin
			active_q <= probe_in.active;
		end
	end

	always_ff @(posedge clk) begin
		probe_q <= nxt;
	end

	always_comb begin
		probe_out        = probe_q;
		probe_out.active = active_q;
	end

endmodule
